// File: rtl/huf_pkg.sv
// ----------------------------------------------------------------------------
// huf_pkg
// Shared sizes, codes and types for the Huffman tree decoder.
// ----------------------------------------------------------------------------
package huf_pkg;

  // Storage sizes
  localparam int MAX_NODES   = 511;
  localparam int STACK_DEPTH = 256;

  // Derived widths
  localparam int NODE_IW  = $clog2(MAX_NODES);        // node index
  localparam int NCNT_W   = $clog2(MAX_NODES + 1);    // node fill count
  localparam int SDEPTH_W = $clog2(STACK_DEPTH + 1);  // stack depth count
  localparam int SADDR_W  = $clog2(STACK_DEPTH);      // stack memory address
  localparam int SYM_W    = 8;

  // Item function codes
  localparam logic [1:0] FN_LEAF  = 2'd0;
  localparam logic [1:0] FN_JOIN  = 2'd1;
  localparam logic [1:0] FN_BIT   = 2'd2;
  localparam logic [1:0] FN_CLEAR = 2'd3;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_UNDERFLOW = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_NOT_READY = 3'd3;
  localparam logic [2:0] ST_NO_CHILD  = 3'd4;

  // One tree node as held in the node store
  typedef struct packed {
    logic               leaf;
    logic [SYM_W-1:0]   sym;
    logic [NODE_IW-1:0] left;
    logic [NODE_IW-1:0] right;
  } node_t;

  // Stack operation request
  typedef struct packed {
    logic clear;
    logic push;   // push one index
    logic merge;  // pop two, push one
  } stk_cmd_t;

  // Stack view seen by the controller
  typedef struct packed {
    logic [SDEPTH_W-1:0] depth;
    logic [NODE_IW-1:0]  tos;
    logic [NODE_IW-1:0]  nos;
  } stk_view_t;

  // One result item
  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             sym_valid;
    logic [2:0]       status;
  } res_t;

endpackage

// File: rtl/huf_node_store.sv
// ----------------------------------------------------------------------------
// huf_node_store
// Tree node memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module huf_node_store (
  input  logic                         clk,
  input  logic                         we,
  input  logic [huf_pkg::NODE_IW-1:0]  waddr,
  input  huf_pkg::node_t               wdata,
  input  logic                         re,
  input  logic [huf_pkg::NODE_IW-1:0]  raddr,
  output huf_pkg::node_t               rdata
);
  import huf_pkg::*;

  node_t mem [MAX_NODES];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/huf_stack.sv
// ----------------------------------------------------------------------------
// huf_stack
// Node index stack: top two entries in registers, the rest in a memory.
// The entry below them is prefetched every cycle, with the push forwarded.
// ----------------------------------------------------------------------------
module huf_stack (
  input  logic                        clk,
  input  logic                        rst,
  input  huf_pkg::stk_cmd_t           cmd,
  input  logic [huf_pkg::NODE_IW-1:0] new_idx,
  output huf_pkg::stk_view_t          view
);
  import huf_pkg::*;

  logic [NODE_IW-1:0]  mem [STACK_DEPTH];
  logic [SDEPTH_W-1:0] depth;
  logic [SDEPTH_W-1:0] depth_next;
  logic [NODE_IW-1:0]  tos;
  logic [NODE_IW-1:0]  nos;
  logic [NODE_IW-1:0]  third;
  logic [SDEPTH_W-1:0] wr_pos;
  logic [SDEPTH_W-1:0] rd_pos;
  logic                spill;

  // depth update
  always_comb begin
    depth_next = depth;
    if (cmd.clear) begin
      depth_next = '0;
    end else if (cmd.push) begin
      depth_next = depth + SDEPTH_W'(1);
    end else if (cmd.merge) begin
      depth_next = depth - SDEPTH_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else begin
      depth <= depth_next;
    end
  end

  // cached top two entries
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      nos <= tos;
      tos <= new_idx;
    end else if (cmd.merge) begin
      nos <= third;
      tos <= new_idx;
    end
  end

  // spill of the second entry into memory on push
  assign wr_pos = depth - SDEPTH_W'(2);
  assign spill  = cmd.push && (depth >= SDEPTH_W'(2));

  always_ff @(posedge clk) begin
    if (spill) begin
      mem[wr_pos[SADDR_W-1:0]] <= nos;
    end
  end

  // third entry: prefetch at the next depth, forward the spilled value
  assign rd_pos = depth_next - SDEPTH_W'(3);

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      third <= nos;
    end else begin
      third <= mem[rd_pos[SADDR_W-1:0]];
    end
  end

  assign view.depth = depth;
  assign view.tos   = tos;
  assign view.nos   = nos;

endmodule

// File: rtl/huf_out_q.sv
// ----------------------------------------------------------------------------
// huf_out_q
// Two-entry result queue between the decoder core and the output channel.
// ----------------------------------------------------------------------------
module huf_out_q (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  huf_pkg::res_t push_data,
  output logic          room,
  output logic          out_valid,
  input  logic          out_ready,
  output huf_pkg::res_t head
);
  import huf_pkg::*;

  res_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt != 2'd0);
  assign room      = (cnt != 2'd2);
  assign head      = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// File: rtl/huffman_tree_decoder_unit.sv
// ----------------------------------------------------------------------------
// huffman_tree_decoder_unit
// Builds a Huffman tree from leaf/join tokens and decodes code bits against it.
// Timing: tree tokens, clear and rejected code bits push their result into the result
//   queue at the transfer; code bits that step the walk first do one node-store read.
// Throughput: tree tokens, clear and rejected code bits 1 per cycle while the result
//   queue has room; a stepping code bit holds off the next item until the node-store
//   read of the child has returned and the walk has advanced.
// Reset: control state cleared at once; node and stack memories are not swept.
// ----------------------------------------------------------------------------
module huffman_tree_decoder_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 func,
  input  logic [huf_pkg::SYM_W-1:0]  leaf_symbol,
  input  logic                       code_bit,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [huf_pkg::SYM_W-1:0]  symbol,
  output logic                       symbol_valid,
  output logic [2:0]                 status
);
  import huf_pkg::*;

  // control state
  logic              closed, closed_next;
  logic              pend, pend_next;
  logic [NCNT_W-1:0] used, used_next;
  node_t             tos_node, tos_node_next;
  node_t             root, root_next;
  node_t             cur, cur_next;

  logic       in_xfer;
  logic       q_room;
  logic       q_push;
  res_t       res;
  res_t       q_head;
  stk_cmd_t   scmd;
  stk_view_t  sview;
  logic       st_we;
  node_t      st_wdata;
  logic       st_re;
  logic [NODE_IW-1:0] st_raddr;
  node_t      st_rdata;
  logic       store_full;

  assign in_ready   = q_room && !pend;
  assign in_xfer    = in_valid && in_ready;
  assign store_full = (used >= NCNT_W'(MAX_NODES));

  // item processing
  always_comb begin
    res           = '0;
    q_push        = 1'b0;
    scmd          = '0;
    st_we         = 1'b0;
    st_wdata      = '0;
    st_re         = 1'b0;
    st_raddr      = cur.left;
    closed_next   = closed;
    pend_next     = 1'b0;
    used_next     = used;
    tos_node_next = tos_node;
    root_next     = root;
    cur_next      = cur;

    if (pend) begin
      // second half of a code bit: child node has arrived
      q_push = 1'b1;
      res.status = ST_OK;
      if (st_rdata.leaf) begin
        res.sym       = st_rdata.sym;
        res.sym_valid = 1'b1;
        cur_next      = root;
      end else begin
        cur_next = st_rdata;
      end
    end else if (in_xfer) begin
      q_push = 1'b1;
      case (func)
        FN_LEAF: begin
          if (!closed) begin
            if (store_full || (sview.depth >= SDEPTH_W'(STACK_DEPTH))) begin
              res.status = ST_FULL;
            end else begin
              st_wdata.leaf = 1'b1;
              st_wdata.sym  = leaf_symbol;
              st_we         = 1'b1;
              scmd.push     = 1'b1;
              used_next     = used + NCNT_W'(1);
              tos_node_next = st_wdata;
            end
          end
        end
        FN_JOIN: begin
          if (!closed) begin
            if (sview.depth == SDEPTH_W'(1)) begin
              closed_next = 1'b1;
              root_next   = tos_node;
              cur_next    = tos_node;
            end else if (sview.depth == '0) begin
              res.status = ST_UNDERFLOW;
            end else if (store_full) begin
              res.status = ST_FULL;
            end else begin
              st_wdata.left  = sview.tos;
              st_wdata.right = sview.nos;
              st_we          = 1'b1;
              scmd.merge     = 1'b1;
              used_next      = used + NCNT_W'(1);
              tos_node_next  = st_wdata;
            end
          end
        end
        FN_BIT: begin
          if (!closed) begin
            res.status = ST_NOT_READY;
          end else if (cur.leaf) begin
            res.status = ST_NO_CHILD;
            cur_next   = root;
          end else begin
            // fetch the child; result follows next cycle
            q_push    = 1'b0;
            st_re     = 1'b1;
            st_raddr  = code_bit ? cur.right : cur.left;
            pend_next = 1'b1;
          end
        end
        FN_CLEAR: begin
          scmd.clear  = 1'b1;
          closed_next = 1'b0;
          used_next   = '0;
        end
        default: begin
          res.status = ST_OK;
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      closed <= 1'b0;
      pend   <= 1'b0;
      used   <= '0;
    end else begin
      closed <= closed_next;
      pend   <= pend_next;
      used   <= used_next;
    end
  end

  // node payload registers
  always_ff @(posedge clk) begin
    tos_node <= tos_node_next;
    root     <= root_next;
    cur      <= cur_next;
  end

  huf_node_store u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (used[NODE_IW-1:0]),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  huf_stack u_stack (
    .clk     (clk),
    .rst     (rst),
    .cmd     (scmd),
    .new_idx (used[NODE_IW-1:0]),
    .view    (sview)
  );

  huf_out_q u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (res),
    .room      (q_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (q_head)
  );

  assign symbol       = q_head.sym;
  assign symbol_valid = q_head.sym_valid;
  assign status       = q_head.status;

  // no new transfer while a child fetch is in flight
  a_interlock: assert property (@(posedge clk) disable iff (rst)
    pend |-> !in_ready)
    else $error("input taken during node fetch");

  // a closed tree always has exactly its root on the stack
  a_closed_depth: assert property (@(posedge clk) disable iff (rst)
    closed |-> (sview.depth == SDEPTH_W'(1)))
    else $error("closed tree with stack depth other than one");

  // a decodable code bit always starts a fetch
  a_fetch: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && (func == FN_BIT) && closed && !cur.leaf) |=> pend)
    else $error("code bit did not start a node fetch");

  // a fetch never stays pending: pend always drops again after it is set
  a_pend_once: assert property (@(posedge clk) disable iff (rst)
    pend |=> !pend)
    else $error("node fetch held for two cycles");

endmodule

// File: sim/huffman_tree_decoder_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// huffman_tree_decoder_unit_tb
// Drives tree tokens, code bits and clears into the Huffman tree decoder with
// random gaps on both channels. Every result is checked in order against a
// local tree builder and walker that tracks the node store, the node stack and
// the decode position.
// ----------------------------------------------------------------------------
module huffman_tree_decoder_unit_tb;
  import huf_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int ITEMS      = 750;

  // One input item waiting for its transfer
  typedef struct {
    logic [1:0]       fn;
    logic [SYM_W-1:0] sym;
    logic             dir;
  } token_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [1:0]       func = FN_LEAF;
  logic [SYM_W-1:0] leaf_symbol = '0;
  logic             code_bit = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [SYM_W-1:0] symbol;
  logic             symbol_valid;
  logic [2:0]       status;

  token_t pending_tokens[$];
  res_t   pending_results[$];
  int     mismatches = 0;
  int     tokens_queued = 0;

  // Tree state as seen from outside
  node_t              tree_nodes [MAX_NODES];
  logic [NODE_IW-1:0] open_nodes [STACK_DEPTH];
  int                 open_count;
  int                 nodes_built;
  logic [NODE_IW-1:0] walk_at;
  logic               tree_done;

  // Handshake pacing
  logic in_taken = 1'b0;
  int   in_wait = 0;
  logic in_calm = 1'b0;
  int   out_hold = 0;
  logic out_calm = 1'b0;
  int   idle_cycles = 0;

  huffman_tree_decoder_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .leaf_symbol  (leaf_symbol),
    .code_bit     (code_bit),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .symbol       (symbol),
    .symbol_valid (symbol_valid),
    .status       (status)
  );

  always #10 clk = ~clk;

  // Most pauses short, a few long
  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // Random field values
  function automatic logic [SYM_W-1:0] rand_sym();
    return SYM_W'($urandom);
  endfunction

  function automatic logic rand_dir();
    return 1'($urandom);
  endfunction

  function automatic void tree_clear();
    open_count  = 0;
    nodes_built = 0;
    walk_at     = '0;
    tree_done   = 1'b0;
  endfunction

  // Apply one item to the tracked tree and return the result it gives
  function automatic res_t tree_step(input logic [1:0] fn, input logic [SYM_W-1:0] sym_in,
                                     input logic dir);
    res_t               r;
    node_t              cur;
    node_t              nxt;
    logic [NODE_IW-1:0] child;
    r = '0;
    r.status = ST_OK;
    case (fn)
      FN_CLEAR: begin
        tree_clear();
      end
      FN_LEAF: begin
        if (!tree_done) begin
          if (nodes_built >= MAX_NODES || open_count >= STACK_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            tree_nodes[nodes_built] = '{leaf: 1'b1, sym: sym_in, left: '0, right: '0};
            open_nodes[open_count] = NODE_IW'(nodes_built);
            open_count++;
            nodes_built++;
          end
        end
      end
      FN_JOIN: begin
        if (!tree_done) begin
          if (open_count == 1) begin
            tree_done = 1'b1;
            walk_at   = open_nodes[0];
          end else if (open_count == 0) begin
            r.status = ST_UNDERFLOW;
          end else if (nodes_built >= MAX_NODES) begin
            r.status = ST_FULL;
          end else begin
            // top of stack goes left, the one below it right
            tree_nodes[nodes_built] = '{leaf: 1'b0, sym: '0,
                                        left: open_nodes[open_count-1],
                                        right: open_nodes[open_count-2]};
            open_count -= 2;
            open_nodes[open_count] = NODE_IW'(nodes_built);
            open_count++;
            nodes_built++;
          end
        end
      end
      default: begin
        if (!tree_done || open_count != 1) begin
          r.status = ST_NOT_READY;
        end else begin
          cur = tree_nodes[walk_at];
          if (cur.leaf) begin
            // single-leaf tree: nowhere to go
            r.status = ST_NO_CHILD;
            walk_at  = open_nodes[0];
          end else begin
            child = dir ? cur.right : cur.left;
            nxt   = tree_nodes[child];
            if (nxt.leaf) begin
              r.sym       = nxt.sym;
              r.sym_valid = 1'b1;
              walk_at     = open_nodes[0];
            end else begin
              walk_at = child;
            end
          end
        end
      end
    endcase
    return r;
  endfunction

  task automatic add_token(input logic [1:0] fn, input logic [SYM_W-1:0] sym, input logic dir);
    token_t t;
    t.fn  = fn;
    t.sym = sym;
    t.dir = dir;
    pending_tokens.push_back(t);
    tokens_queued++;
  endtask

  // Input driver: next item or a gap after each transfer
  always @(negedge clk) begin
    token_t tok;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_wait > 0) begin
        in_valid <= 1'b0;
        in_wait  <= in_wait - 1;
      end else if (pending_tokens.size() != 0) begin
        tok = pending_tokens.pop_front();
        func        <= tok.fn;
        leaf_symbol <= tok.sym;
        code_bit    <= tok.dir;
        in_valid    <= 1'b1;
        in_wait     <= in_calm ? 0 : pick_pause();
        if ($urandom_range(0, 49) == 0) in_calm <= !in_calm;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output back-pressure
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (out_hold > 0) begin
      out_ready <= 1'b0;
      out_hold  <= out_hold - 1;
    end else begin
      out_ready <= 1'b1;
      if (!out_calm && $urandom_range(0, 3) == 0) out_hold <= pick_pause();
      if ($urandom_range(0, 199) == 0) out_calm <= !out_calm;
    end
  end

  // Predict on each input transfer, check on each output transfer
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      tree_clear();
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready)
        pending_results.push_back(tree_step(func, leaf_symbol, code_bit));
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with none expected: symbol=%0d symbol_valid=%0b status=%0d",
                   $time, symbol, symbol_valid, status);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (symbol !== want.sym) begin
            $display("%0t: symbol expected %0d actual %0d", $time, want.sym, symbol);
            mismatches++;
          end
          if (symbol_valid !== want.sym_valid) begin
            $display("%0t: symbol_valid expected %0b actual %0b",
                     $time, want.sym_valid, symbol_valid);
            mismatches++;
          end
          if (status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status);
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus and end of run
  initial begin
    int n_leaves;
    int leaves_left;
    int depth;
    int n_bits;

    // empty-stack join, bits before any tree
    add_token(FN_JOIN, 8'h00, 1'b0);
    add_token(FN_BIT, 8'hFF, 1'b0);
    add_token(FN_BIT, 8'h00, 1'b1);
    // single-leaf tree: bits find no child, later tokens ignored
    add_token(FN_LEAF, 8'hFF, 1'b1);
    add_token(FN_JOIN, 8'h00, 1'b0);
    add_token(FN_BIT, 8'h00, 1'b0);
    add_token(FN_BIT, 8'h00, 1'b1);
    add_token(FN_LEAF, 8'h12, 1'b0);
    add_token(FN_JOIN, 8'h34, 1'b1);
    add_token(FN_BIT, 8'h00, 1'b1);
    add_token(FN_CLEAR, 8'hFF, 1'b1);
    add_token(FN_BIT, 8'h00, 1'b0);
    // three-leaf tree, with a bit while still building
    add_token(FN_LEAF, 8'h00, 1'b0);
    add_token(FN_LEAF, 8'hFF, 1'b0);
    add_token(FN_BIT, 8'h00, 1'b1);
    add_token(FN_JOIN, 8'h00, 1'b0);
    add_token(FN_LEAF, 8'h5A, 1'b0);
    add_token(FN_JOIN, 8'h00, 1'b0);
    add_token(FN_JOIN, 8'h00, 1'b0);
    add_token(FN_BIT, 8'h00, 1'b0);
    add_token(FN_BIT, 8'h00, 1'b1);
    add_token(FN_BIT, 8'h00, 1'b0);
    add_token(FN_BIT, 8'h00, 1'b1);
    add_token(FN_BIT, 8'h00, 1'b1);
    add_token(FN_BIT, 8'h00, 1'b0);

    // stack full, then join down and fill the store with nodes still open
    add_token(FN_CLEAR, rand_sym(), rand_dir());
    for (int i = 0; i < STACK_DEPTH; i++) add_token(FN_LEAF, rand_sym(), rand_dir());
    add_token(FN_LEAF, rand_sym(), rand_dir());
    for (int i = 0; i < STACK_DEPTH - 2; i++) add_token(FN_JOIN, rand_sym(), rand_dir());
    add_token(FN_LEAF, rand_sym(), rand_dir());
    add_token(FN_JOIN, rand_sym(), rand_dir());
    add_token(FN_LEAF, rand_sym(), rand_dir());
    add_token(FN_BIT, rand_sym(), rand_dir());

    // random part: mostly well-formed trees followed by code bits
    while (tokens_queued < ITEMS) begin
      if ($urandom_range(0, 99) < 85) begin
        add_token(FN_CLEAR, rand_sym(), rand_dir());
        case ($urandom_range(0, 19))
          0:       n_leaves = $urandom_range(41, 120);
          1, 2, 3,
          4, 5:    n_leaves = $urandom_range(9, 40);
          default: n_leaves = $urandom_range(1, 8);
        endcase
        leaves_left = n_leaves;
        depth = 0;
        while (leaves_left > 0 || depth > 1) begin
          if (depth >= 2 && (leaves_left == 0 || $urandom_range(0, 2) == 0)) begin
            add_token(FN_JOIN, rand_sym(), rand_dir());
            depth--;
          end else begin
            add_token(FN_LEAF, rand_sym(), rand_dir());
            depth++;
            leaves_left--;
          end
          if ($urandom_range(0, 29) == 0) add_token(FN_BIT, rand_sym(), rand_dir());
        end
        add_token(FN_JOIN, rand_sym(), rand_dir());
        if ($urandom_range(0, 4) == 0)
          add_token($urandom_range(0, 1) ? FN_LEAF : FN_JOIN, rand_sym(), rand_dir());
        n_bits = $urandom_range(4, 40);
        for (int i = 0; i < n_bits; i++) add_token(FN_BIT, rand_sym(), rand_dir());
      end else begin
        // noise: any function, any fields
        n_bits = $urandom_range(1, 4);
        for (int i = 0; i < n_bits; i++) add_token(2'($urandom), rand_sym(), rand_dir());
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_tokens.size() != 0 || in_valid || pending_results.size() != 0)
      @(posedge clk);
    repeat (8) @(negedge clk);

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
